// ===== design/memory_lcd_line_framer_macros.svh =====
// Assertion macros used by the line framer top-level design file.
`ifndef MEMORY_LCD_LINE_FRAMER_MACROS_SVH
`define MEMORY_LCD_LINE_FRAMER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LCDLF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define LCDLF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/lcdlf_pkg.sv =====
// Types, constants and helper functions of the memory LCD line framer.
package lcdlf_pkg;

   localparam int LINE_BYTES_DEFAULT = 12;

   localparam logic [7:0] BYTE_WRITE_LINE = 8'h80;
   localparam logic [7:0] BYTE_VCOM       = 8'h40;
   localparam logic [7:0] BYTE_CLEAR      = 8'h20;
   localparam logic [7:0] BYTE_PAD        = 8'h00;
   localparam logic [7:0] BYTE_WHITE      = 8'hFF;
   localparam logic [7:0] BYTE_BLACK      = 8'h00;
   localparam logic [7:0] BIT_FIRST_PIXEL = 8'h80;

   typedef enum logic [2:0] {
      CMD_PIXEL = 3'd0,
      CMD_WRITE = 3'd1,
      CMD_COPY  = 3'd2,
      CMD_FILL  = 3'd3,
      CMD_SEND  = 3'd4,
      CMD_CLEAR = 3'd5,
      CMD_VCOM  = 3'd6
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEAD,
      ST_DATA,
      ST_PAD,
      ST_CLOSE,
      ST_TAIL,
      ST_MODIFY
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic fill_en;
      logic fill_white;
   } mem_ctl_type;

   function automatic logic [7:0] reverse_byte(input logic [7:0] value);
      logic [7:0] result;
      for (int i = 0; i < 8; i++) begin
         result[i] = value[7 - i];
      end
      return result;
   endfunction

endpackage

// ===== design/lcdlf_line_mem.sv =====
// Line buffer memory with per-byte valid bits and a common fill value.
module lcdlf_line_mem #(
   parameter int LineBytes = lcdlf_pkg::LINE_BYTES_DEFAULT,
   parameter int AddrWidth = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  lcdlf_pkg::mem_ctl_type    ctl,
   input  logic [AddrWidth-1:0]      rd_addr,
   input  logic [AddrWidth-1:0]      wr_addr,
   input  logic [7:0]                wr_data,
   output logic [7:0]                rd_byte
);
   import lcdlf_pkg::*;

   logic [7:0]           line_mem [LineBytes];
   logic [LineBytes-1:0] valid_ff;
   logic [LineBytes-1:0] valid_in;
   logic [7:0]           fill_ff;
   logic [7:0]           fill_in;
   logic [7:0]           rd_data_ff;
   logic                 rd_valid_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_data_ff  <= line_mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      fill_in  = fill_ff;
      if (ctl.fill_en) begin
         valid_in = '0;
         fill_in  = ctl.fill_white ? BYTE_WHITE : BYTE_BLACK;
      end else if (ctl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         fill_ff  <= BYTE_WHITE;
      end else begin
         valid_ff <= valid_in;
         fill_ff  <= fill_in;
      end
   end

   assign rd_byte = rd_valid_ff ? rd_data_ff : fill_ff;

endmodule

// ===== design/memory_lcd_line_framer.sv =====
// Top level of the memory LCD line framer: command sequencer and output word register.
//
//   Channel   Handshake             Ports
//   request   start high, busy low  req_cmd .. req_close_frame
//   response  rsp_strobe, one cycle rsp_spi_byte, rsp_select_end, rsp_last
//
// A line send produces LineBytes + 2 to LineBytes + 4 output words, one word per cycle;
// the buffer is read one byte ahead through the memory's registered read port.
// Pixel and copy edits read the byte, then modify and write it back in ST_MODIFY; byte
// writes and fills act at once. Clear display and VCOM toggle send a word, then a tail word.
// Reset is synchronous; the buffer reads as white afterwards with no clearing pass.
// Words appear in the cycle after they are produced and cannot be stalled.
module memory_lcd_line_framer #(
   parameter int LineBytes = lcdlf_pkg::LINE_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_cmd,
   input  logic [8:0] req_pixel_index,
   input  logic       req_white,
   input  logic [5:0] req_byte_index,
   input  logic [5:0] req_source_index,
   input  logic [7:0] req_byte_value,
   input  logic [7:0] req_line_address,
   input  logic       req_open_frame,
   input  logic       req_close_frame,
   output logic       rsp_strobe,
   output logic [7:0] rsp_spi_byte,
   output logic       rsp_select_end,
   output logic       rsp_last
);
   import lcdlf_pkg::*;

   `include "memory_lcd_line_framer_macros.svh"

   localparam int AddrWidth  = (LineBytes > 1) ? $clog2(LineBytes) : 1;
   localparam int PixelCount = LineBytes * 8;
   localparam logic [AddrWidth-1:0] LastAddr = AddrWidth'(LineBytes - 1);

   state_type            state_ff, state_in;
   logic                 copy_ff, copy_in;
   logic                 white_ff, white_in;
   logic [2:0]           bit_ff, bit_in;
   logic [AddrWidth-1:0] wr_addr_ff, wr_addr_in;
   logic [7:0]           line_addr_ff, line_addr_in;
   logic                 close_ff, close_in;
   logic [AddrWidth-1:0] idx_ff, idx_in;
   logic                 vcom_ff, vcom_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic [7:0]           rsp_byte_ff, rsp_byte_in;
   logic                 rsp_sel_ff, rsp_sel_in;
   logic                 rsp_last_ff, rsp_last_in;

   mem_ctl_type          mem_ctl;
   logic [AddrWidth-1:0] mem_rd_addr;
   logic [AddrWidth-1:0] mem_wr_addr;
   logic [7:0]           mem_wr_data;
   logic [7:0]           rd_byte;

   logic                 accept;
   cmd_type              cmd_w;
   logic                 pix_ok;
   logic                 dst_ok;
   logic                 src_ok;
   logic [8:0]           pix_off;
   logic [AddrWidth-1:0] pix_addr;
   logic [AddrWidth-1:0] dst_addr;
   logic [AddrWidth-1:0] src_addr;
   logic [7:0]           pix_mask;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign cmd_w   = cmd_type'(req_cmd);
   assign pix_ok  = (req_pixel_index != 9'd0) && (req_pixel_index <= 9'(PixelCount));
   assign dst_ok  = (req_byte_index != 6'd0) && (req_byte_index <= 6'(LineBytes));
   assign src_ok  = (req_source_index != 6'd0) && (req_source_index <= 6'(LineBytes));
   assign pix_off  = req_pixel_index - 9'd1;
   assign pix_addr = AddrWidth'(pix_off[8:3]);
   assign dst_addr = AddrWidth'(req_byte_index - 6'd1);
   assign src_addr = AddrWidth'(req_source_index - 6'd1);
   assign pix_mask = BIT_FIRST_PIXEL >> bit_ff;

   lcdlf_line_mem #(
      .LineBytes (LineBytes),
      .AddrWidth (AddrWidth)
   ) u_line_mem (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mem_ctl),
      .rd_addr (mem_rd_addr),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_byte (rd_byte)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (cmd_w) inside
                  CMD_PIXEL: begin
                     if (pix_ok) state_in = ST_MODIFY;
                  end
                  CMD_COPY: begin
                     if (dst_ok && src_ok) state_in = ST_MODIFY;
                  end
                  CMD_SEND: begin
                     state_in = req_open_frame ? ST_HEAD : ST_DATA;
                  end
                  CMD_CLEAR, CMD_VCOM: begin
                     state_in = ST_TAIL;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_HEAD: begin
            state_in = ST_DATA;
         end
         ST_DATA: begin
            if (idx_ff == LastAddr) state_in = ST_PAD;
         end
         ST_PAD: begin
            state_in = close_ff ? ST_CLOSE : ST_IDLE;
         end
         ST_CLOSE, ST_TAIL, ST_MODIFY: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      copy_in       = copy_ff;
      white_in      = white_ff;
      bit_in        = bit_ff;
      wr_addr_in    = wr_addr_ff;
      line_addr_in  = line_addr_ff;
      close_in      = close_ff;
      idx_in        = idx_ff;
      vcom_in       = vcom_ff;
      rsp_strobe_in = 1'b0;
      rsp_byte_in   = BYTE_PAD;
      rsp_sel_in    = 1'b0;
      rsp_last_in   = 1'b0;
      mem_ctl       = '0;
      mem_rd_addr   = '0;
      mem_wr_addr   = wr_addr_ff;
      mem_wr_data   = BYTE_PAD;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               copy_in      = (cmd_w == CMD_COPY);
               white_in     = req_white;
               bit_in       = pix_off[2:0];
               wr_addr_in   = (cmd_w == CMD_PIXEL) ? pix_addr : dst_addr;
               line_addr_in = req_line_address;
               close_in     = req_close_frame;
               unique case (cmd_w) inside
                  CMD_PIXEL: begin
                     mem_ctl.rd_en = pix_ok;
                     mem_rd_addr   = pix_addr;
                  end
                  CMD_WRITE: begin
                     mem_ctl.wr_en = dst_ok;
                     mem_wr_addr   = dst_addr;
                     mem_wr_data   = req_byte_value;
                  end
                  CMD_COPY: begin
                     mem_ctl.rd_en = dst_ok && src_ok;
                     mem_rd_addr   = src_addr;
                  end
                  CMD_FILL: begin
                     mem_ctl.fill_en    = 1'b1;
                     mem_ctl.fill_white = req_white;
                  end
                  CMD_SEND: begin
                     rsp_strobe_in = 1'b1;
                     idx_in        = '0;
                     if (req_open_frame) begin
                        rsp_byte_in = BYTE_WRITE_LINE;
                     end else begin
                        rsp_byte_in   = reverse_byte(req_line_address);
                        mem_ctl.rd_en = 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     rsp_strobe_in = 1'b1;
                     rsp_byte_in   = BYTE_CLEAR;
                  end
                  CMD_VCOM: begin
                     vcom_in       = !vcom_ff;
                     rsp_strobe_in = 1'b1;
                     rsp_byte_in   = vcom_ff ? BYTE_PAD : BYTE_VCOM;
                  end
                  default: begin
                     rsp_strobe_in = 1'b0;
                  end
               endcase
            end
         end
         ST_HEAD: begin
            rsp_strobe_in = 1'b1;
            rsp_byte_in   = reverse_byte(line_addr_ff);
            mem_ctl.rd_en = 1'b1;
            idx_in        = '0;
         end
         ST_DATA: begin
            rsp_strobe_in = 1'b1;
            rsp_byte_in   = rd_byte;
            if (idx_ff != LastAddr) begin
               mem_ctl.rd_en = 1'b1;
               mem_rd_addr   = idx_ff + 1'b1;
               idx_in        = idx_ff + 1'b1;
            end
         end
         ST_PAD: begin
            rsp_strobe_in = 1'b1;
            rsp_last_in   = !close_ff;
         end
         ST_CLOSE, ST_TAIL: begin
            rsp_strobe_in = 1'b1;
            rsp_sel_in    = 1'b1;
            rsp_last_in   = 1'b1;
         end
         ST_MODIFY: begin
            mem_ctl.wr_en = 1'b1;
            if (copy_ff) begin
               mem_wr_data = rd_byte;
            end else if (white_ff) begin
               mem_wr_data = rd_byte | pix_mask;
            end else begin
               mem_wr_data = rd_byte & ~pix_mask;
            end
         end
         default: begin
            rsp_strobe_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         vcom_ff       <= 1'b1;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         vcom_ff       <= vcom_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      copy_ff      <= copy_in;
      white_ff     <= white_in;
      bit_ff       <= bit_in;
      wr_addr_ff   <= wr_addr_in;
      line_addr_ff <= line_addr_in;
      close_ff     <= close_in;
      idx_ff       <= idx_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_sel_ff   <= rsp_sel_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_spi_byte   = rsp_byte_ff;
   assign rsp_select_end = rsp_sel_ff;
   assign rsp_last       = rsp_last_ff;

   `LCDLF_ASSERT_NEXT(a_edit_silent,
      start && !busy && req_cmd != CMD_SEND && req_cmd != CMD_CLEAR && req_cmd != CMD_VCOM,
      !rsp_strobe, "buffer edit produced an output word")
   `LCDLF_ASSERT_NEXT(a_item_contiguous, rsp_strobe && !rsp_last, rsp_strobe,
      "gap between the output words of one item")
   `LCDLF_ASSERT_NOW(a_select_end_last, rsp_strobe && rsp_select_end, rsp_last,
      "select end on a word that is not the last")
   `LCDLF_ASSERT_NOW(a_busy_mid_item, rsp_strobe && !rsp_last, busy,
      "sequencer idle before the last word of an item")
   `LCDLF_ASSERT_NEXT(a_send_busy, start && !busy && req_cmd == CMD_SEND, busy,
      "line send did not occupy the sequencer")

endmodule
